[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside of reset
`define HTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define HTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HTS_ASSERT(lbl, prop, msg)
`define HTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/hts_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Humidity sensor sequencer package
// Shared codes, payload types and conversion constants.
// ---------------------------------------------------------------------------
package hts_pkg;

    // Conversion constants
    localparam int unsigned FULL_SCALE      = 16383;
    localparam int unsigned HUM_SCALE       = 100;
    localparam int unsigned TEMP_SCALE      = 165;
    localparam int unsigned TEMP_OFFSET     = 40;
    localparam int unsigned TENTH_SCALE     = 10;
    localparam int unsigned WAIT_TICKS_INIT = 40;

    // Input commands
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_END      = 2'd1,
        CMD_BUS_DONE = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    // Bus requests to the I2C engine
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_WAKE = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_WAKE     = 3'd1,
        PH_DELAY    = 3'd2,
        PH_READ     = 3'd3,
        PH_COMPLETE = 3'd4
    } phase_t;

    // Input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] read_data;
    } in_t;

    // Result item
    typedef struct packed {
        logic [1:0]        bus_action;
        logic              complete;
        logic [6:0]        humidity_whole;
        logic [3:0]        humidity_tenth;
        logic signed [7:0] temperature_whole;
        logic [3:0]        temperature_tenth;
    } out_t;

    // Converted measurement values
    typedef struct packed {
        logic [6:0]        humidity_whole;
        logic [3:0]        humidity_tenth;
        logic signed [7:0] temperature_whole;
        logic [3:0]        temperature_tenth;
    } conv_t;

endpackage

[rtl/hts_convert.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Measurement conversion
// Turns the four latched sensor bytes into humidity and temperature values.
// Division by the full scale 2^14-1 folds the upper bits back onto the
// lower ones, then corrects with one compare and subtract.
// ---------------------------------------------------------------------------
module hts_convert
(
    input  logic [31:0]   raw,
    output hts_pkg::conv_t conv
);

    typedef struct packed {
        logic [7:0]  q;
        logic [13:0] r;
    } div_t;

    // Divide by 16383 for values below 2^22: x = hi*16383 + (hi + lo)
    function automatic div_t div_fs(input logic [21:0] x);
        logic [14:0] sum;
        div_t        d;
        sum = 15'(x[21:14]) + 15'(x[13:0]);
        if (sum >= 15'(hts_pkg::FULL_SCALE))
        begin
            d.q = x[21:14] + 8'd1;
            d.r = 14'(sum - 15'(hts_pkg::FULL_SCALE));
        end
        else
        begin
            d.q = x[21:14];
            d.r = sum[13:0];
        end
        return d;
    endfunction

    logic [13:0] hum_raw;
    logic [13:0] temp_raw;
    div_t        hum_div;
    div_t        hum_tenth_div;
    div_t        temp_div;
    div_t        temp_tenth_div;
    logic [7:0]  temp_int;

    // Pick the raw 14-bit codes out of the read bytes
    assign hum_raw  = raw[29:16];
    assign temp_raw = raw[15:2];

    // Scale and divide for the whole parts
    assign hum_div  = div_fs(22'(hum_raw) * 22'(hts_pkg::HUM_SCALE));
    assign temp_div = div_fs(22'(temp_raw) * 22'(hts_pkg::TEMP_SCALE));

    // Tenths digit from the remainder
    assign hum_tenth_div  = div_fs(22'(hum_div.r) * 22'(hts_pkg::TENTH_SCALE));
    assign temp_tenth_div = div_fs(22'(temp_div.r) * 22'(hts_pkg::TENTH_SCALE));

    // Remove the temperature offset, wrapping in eight bits
    assign temp_int = temp_div.q - 8'(hts_pkg::TEMP_OFFSET);

    assign conv.humidity_whole    = hum_div.q[6:0];
    assign conv.humidity_tenth    = hum_tenth_div.q[3:0];
    assign conv.temperature_whole = $signed(temp_int);
    assign conv.temperature_tenth = temp_tenth_div.q[3:0];

endmodule

[rtl/humidity_sensor_measure_sequencer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Humidity sensor measure sequencer
// Sequences one wake/delay/read measurement of an I2C humidity and
// temperature sensor and reports the converted values.
// ---------------------------------------------------------------------------
// Each command transfer produces exactly one result transfer. The block takes
// one command per clock cycle; the result is written into the output register
// at its command transfer, and the command side is held off only while that
// register is full and the result side stalls. Phase update and
// value conversion are one combinational pass from the state registers into
// the output register. A start command requests the wake write, a bus-done
// moves on to the tick delay, the tick that reaches wait_ticks requests the
// four-byte read, and the bus-done of that read latches the bytes and raises
// complete until an end or start command. Value fields read zero otherwise.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module humidity_sensor_measure_sequencer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  hts_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output hts_pkg::out_t out_data
);

    hts_pkg::phase_t  phase_reg;
    hts_pkg::phase_t  phase_next;
    logic [15:0]      tick_count_reg;
    logic [15:0]      tick_count_next;
    logic [15:0]      tick_inc;
    logic [31:0]      raw_sample_reg;
    logic [31:0]      raw_sample_next;
    logic [15:0]      wait_ticks_reg;
    hts_pkg::action_t action;
    hts_pkg::cmd_t    cmd;
    hts_pkg::conv_t   conv;
    hts_pkg::out_t    out_data_reg;
    hts_pkg::out_t    out_data_next;
    logic             out_valid_reg;
    logic             in_fire;

    // Hold off commands while the result register cannot drain
    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;
    assign cmd      = hts_pkg::cmd_t'(in_data.cmd);

    // Saturating tick count
    assign tick_inc = (tick_count_reg != 16'hFFFF) ? (tick_count_reg + 16'd1)
                                                   : tick_count_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wait_ticks_reg <= 16'(hts_pkg::WAIT_TICKS_INIT);
        else if (cfg_wr_en)
            wait_ticks_reg <= cfg_wr_data;
    end

    // Phase and measurement state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hts_pkg::PH_IDLE;
            tick_count_reg <= '0;
            raw_sample_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            raw_sample_reg <= raw_sample_next;
        end
    end

    // Next phase and bus request for the current command
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        raw_sample_next = raw_sample_reg;
        action          = hts_pkg::ACT_NONE;
        case (cmd)
            hts_pkg::CMD_START:
            begin
                phase_next = hts_pkg::PH_WAKE;
                action     = hts_pkg::ACT_WAKE;
            end
            hts_pkg::CMD_END:
            begin
                phase_next = hts_pkg::PH_IDLE;
            end
            hts_pkg::CMD_BUS_DONE:
            begin
                if (phase_reg == hts_pkg::PH_WAKE)
                begin
                    tick_count_next = '0;
                    phase_next      = hts_pkg::PH_DELAY;
                end
                else if (phase_reg == hts_pkg::PH_READ)
                begin
                    raw_sample_next = in_data.read_data;
                    phase_next      = hts_pkg::PH_COMPLETE;
                end
            end
            hts_pkg::CMD_TICK:
            begin
                if (phase_reg == hts_pkg::PH_DELAY)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= wait_ticks_reg)
                    begin
                        action     = hts_pkg::ACT_READ;
                        phase_next = hts_pkg::PH_READ;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Convert the sample that stands after this command
    hts_convert u_convert
    (
        .raw  (raw_sample_next),
        .conv (conv)
    );

    // Assemble the result; values read zero unless complete
    always_comb
    begin
        out_data_next            = '0;
        out_data_next.bus_action = action;
        out_data_next.complete   = (phase_next == hts_pkg::PH_COMPLETE);
        if (phase_next == hts_pkg::PH_COMPLETE)
        begin
            out_data_next.humidity_whole    = conv.humidity_whole;
            out_data_next.humidity_tenth    = conv.humidity_tenth;
            out_data_next.temperature_whole = conv.temperature_whole;
            out_data_next.temperature_tenth = conv.temperature_tenth;
        end
    end

    // Result valid: set on a command transfer, drop once the result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= in_fire | (out_valid_reg & out_stall);
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assertions
    `HTS_ASSERT(a_complete_no_bus, out_valid_reg && out_data_reg.complete |-> out_data_reg.bus_action == hts_pkg::ACT_NONE, "bus request while complete")
    `HTS_ASSERT(a_idle_values_zero, out_valid_reg && !out_data_reg.complete |-> out_data_reg.humidity_whole == 7'd0 && out_data_reg.temperature_whole == 8'sd0, "values not zero while incomplete")
    `HTS_ASSERT(a_read_from_delay, in_fire && phase_reg != hts_pkg::PH_DELAY |=> out_data_reg.bus_action != hts_pkg::ACT_READ, "read issued outside delay phase")
    `HTS_ASSERT(a_tick_reaches_read, in_fire && cmd == hts_pkg::CMD_TICK && phase_reg == hts_pkg::PH_DELAY && tick_count_reg >= wait_ticks_reg |=> phase_reg == hts_pkg::PH_READ, "delay did not end on reaching wait")
    `HTS_ASSERT(a_humidity_range, out_valid_reg |-> out_data_reg.humidity_whole <= 7'd100 && out_data_reg.humidity_tenth <= 4'd9, "humidity out of range")
    `HTS_ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> out_valid_reg, "input stalled with empty result register")

endmodule
